// ===== hdl/wert_pkg.sv =====
`default_nettype none

package wert_pkg;

  localparam int RING_DEPTH = 64;

  // request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_CHECK = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_ENABLE    = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_WINDOW    = 2'd2;
  localparam logic [1:0] CFG_HOLDOFF   = 2'd3;

  localparam logic        ENABLE_RST    = 1'b1;
  localparam logic [9:0]  THRESHOLD_RST = 10'd5;
  localparam logic [9:0]  THRESHOLD_MIN = 10'd1;
  localparam logic [9:0]  THRESHOLD_MAX = 10'd1000;
  localparam logic [18:0] WINDOW_RST    = 19'd60000;
  localparam logic [18:0] WINDOW_MIN    = 19'd1000;
  localparam logic [18:0] WINDOW_MAX    = 19'd300000;
  localparam logic [31:0] HOLDOFF_RST   = 32'd30000;

  localparam logic [6:0]  COUNT_MAX     = 7'd127;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] event_time;
  } in_word_t;

  typedef struct packed {
    logic        fired;
    logic [6:0]  window_count;
    logic [31:0] total_detections;
    logic [31:0] triggers_fired;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DECIDE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/windowed_event_rate_trigger.sv =====
`default_nettype none

// Channel  Direction  Handshake            Word
// -------  ---------  -------------------  ------------------------------------
// in       sink       in_valid/in_ready    req_type, event_time
// out      source     out_valid/out_ready  fired, window_count, totals
// cfg      sink       cfg_we (no wait)     cfg_idx selects register, cfg_data
//
// Per word: an enabled add writes its stamp to the ring and then scans it; an enabled check
// scans the ring; clear, disabled and unused words go straight to DONE. The ring scan makes
// one memory read and one window compare per stored stamp through one compare unit. A new
// word is accepted only in IDLE, once the previous word has left DONE.
// rst is synchronous: registers go to their defaults, ring is empty (fill 0).
// A finished word waits in the output register; DONE stalls until out_ready frees it.

module windowed_event_rate_trigger #(
  parameter int RING_DEPTH = wert_pkg::RING_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire wert_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output wert_pkg::out_word_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_idx,
  input  wire logic [31:0]        cfg_data
);

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  // configuration registers
  logic        enable;
  logic [9:0]  fire_threshold;
  logic [18:0] window_ms;
  logic [31:0] holdoff_ms;

  // ring and its bookkeeping; entries past fill_count are never read,
  // so the ring itself needs no clearing
  logic [31:0]      ring [RING_DEPTH];
  logic [31:0]      rd_data;
  logic [IDX_W-1:0] write_slot;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] scan_idx;
  logic             rd_pend;

  // statistics
  logic [31:0] detection_total;
  logic [31:0] trigger_total;
  logic [31:0] last_fire_time;
  logic        has_fired;

  // per-word working registers
  logic [1:0]  req;
  logic [31:0] now;
  logic [31:0] start;
  logic [6:0]  count;
  logic        fire_flag;

  wert_pkg::state_t state, state_next;

  logic accept;
  logic mem_we;
  logic rd_en;
  logic load_out;
  logic hit;
  logic holdoff_ok;
  logic [31:0] since_fire;

  assign accept = in_valid && in_ready;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= wert_pkg::ENABLE_RST;
      fire_threshold  <= wert_pkg::THRESHOLD_RST;
      window_ms       <= wert_pkg::WINDOW_RST;
      holdoff_ms      <= wert_pkg::HOLDOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        wert_pkg::CFG_ENABLE: begin
          enable <= cfg_data[0];
        end
        wert_pkg::CFG_THRESHOLD: begin
          // out-of-range threshold is dropped
          if (cfg_data[9:0] >= wert_pkg::THRESHOLD_MIN &&
              cfg_data[9:0] <= wert_pkg::THRESHOLD_MAX) begin
            fire_threshold <= cfg_data[9:0];
          end
        end
        wert_pkg::CFG_WINDOW: begin
          if (cfg_data[18:0] >= wert_pkg::WINDOW_MIN &&
              cfg_data[18:0] <= wert_pkg::WINDOW_MAX) begin
            window_ms <= cfg_data[18:0];
          end
        end
        wert_pkg::CFG_HOLDOFF: begin
          holdoff_ms <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      wert_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (enable && in_data.req_type == wert_pkg::REQ_ADD) begin
            state_next = wert_pkg::ST_WRITE;
          end else if (enable && in_data.req_type == wert_pkg::REQ_CHECK) begin
            state_next = wert_pkg::ST_SCAN;
          end else begin
            state_next = wert_pkg::ST_DONE;
          end
        end
      end
      wert_pkg::ST_WRITE: begin
        state_next = wert_pkg::ST_SCAN;
      end
      wert_pkg::ST_SCAN: begin
        if (scan_idx == fill_count && !rd_pend) begin
          state_next = wert_pkg::ST_DECIDE;
        end
      end
      wert_pkg::ST_DECIDE: begin
        state_next = wert_pkg::ST_DONE;
      end
      wert_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = wert_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wert_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      wert_pkg::ST_IDLE:   in_ready = 1'b1;
      wert_pkg::ST_WRITE:  mem_we   = 1'b1;
      wert_pkg::ST_SCAN:   rd_en    = (scan_idx != fill_count);
      wert_pkg::ST_DECIDE: begin
      end
      wert_pkg::ST_DONE:   load_out = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wert_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------- ring memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[write_slot] <= now;
    end
    if (rd_en) begin
      rd_data <= ring[scan_idx[IDX_W-1:0]];
    end
  end

  // window test: start <= stamp <= now
  assign hit        = (rd_data <= now) && (rd_data >= start);
  assign since_fire = now - last_fire_time;
  assign holdoff_ok = !has_fired || (since_fire > holdoff_ms);

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      req       <= in_data.req_type;
      now       <= in_data.event_time;
      // early time: window starts at zero instead of wrapping
      start     <= (in_data.event_time < {13'd0, window_ms}) ? 32'd0
                 : in_data.event_time - {13'd0, window_ms};
      count     <= '0;
      fire_flag <= 1'b0;
      scan_idx  <= '0;
    end
    if (rd_en) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end
    if (state == wert_pkg::ST_SCAN && rd_pend && hit && count != wert_pkg::COUNT_MAX) begin
      count <= count + 7'd1;
    end
    if (state == wert_pkg::ST_DECIDE && req == wert_pkg::REQ_CHECK &&
        {3'd0, count} >= fire_threshold && holdoff_ok) begin
      fire_flag <= 1'b1;
    end
    if (load_out) begin
      out_data.fired            <= fire_flag;
      out_data.window_count     <= count;
      out_data.total_detections <= detection_total;
      out_data.triggers_fired   <= trigger_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot      <= '0;
      fill_count      <= '0;
      detection_total <= '0;
      trigger_total   <= '0;
      last_fire_time  <= '0;
      has_fired       <= 1'b0;
      rd_pend         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (accept && in_data.req_type == wert_pkg::REQ_CLEAR) begin
        // clear item: empty ring, zero statistics, registers untouched
        write_slot      <= '0;
        fill_count      <= '0;
        detection_total <= '0;
        trigger_total   <= '0;
        last_fire_time  <= '0;
        has_fired       <= 1'b0;
      end
      if (mem_we) begin
        write_slot <= (write_slot == IDX_W'(RING_DEPTH - 1)) ? '0
                    : write_slot + IDX_W'(1);
        if (fill_count != CNT_W'(RING_DEPTH)) begin
          fill_count <= fill_count + CNT_W'(1);
        end
        detection_total <= detection_total + 32'd1;
      end
      if (state == wert_pkg::ST_DECIDE && req == wert_pkg::REQ_CHECK &&
          {3'd0, count} >= fire_threshold && holdoff_ok) begin
        last_fire_time <= now;
        trigger_total  <= trigger_total + 32'd1;
        has_fired      <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(RING_DEPTH))
    else $error("fill count past ring depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == wert_pkg::ST_SCAN |-> scan_idx <= fill_count)
    else $error("scan index past fill count");

  a_fire_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.fired |-> {3'd0, out_data.window_count} >= fire_threshold)
    else $error("trigger below threshold");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.req_type == wert_pkg::REQ_CLEAR |=>
      fill_count == '0 && detection_total == 32'd0 && !has_fired)
    else $error("clear item left state behind");

endmodule

`default_nettype wire
